// ----- hdl/lpsc_pkg.sv -----
// ----------------------------------------------------------------------------
// LSB pixel steganography codec package
// Shared types, register indexes and status codes of the codec.
// ----------------------------------------------------------------------------
package lpsc_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] CFG_DIRECTION      = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BITS_PER_PIXEL = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MESSAGE_LENGTH = 2'd2;

  localparam logic [1:0] ST_RUNNING   = 2'd0;
  localparam logic [1:0] ST_DONE      = 2'd1;
  localparam logic [1:0] ST_MAGIC_ERR = 2'd2;
  localparam logic [1:0] ST_RATE_ERR  = 2'd3;

  localparam logic [7:0] MAGIC_EXPECTED = 8'hAA;
  localparam logic [7:0] HDR_BYTE_MASK  = 8'h7F;

  localparam logic [2:0] RATE_ONE  = 3'd1;
  localparam logic [2:0] RATE_TWO  = 3'd2;
  localparam logic [2:0] RATE_FOUR = 3'd4;

  typedef enum logic [6:0] {
    PH_MAGIC     = 7'b0000001,
    PH_LENGTH    = 7'b0000010,
    PH_RATE      = 7'b0000100,
    PH_MESSAGE   = 7'b0001000,
    PH_DONE      = 7'b0010000,
    PH_MAGIC_ERR = 7'b0100000,
    PH_RATE_ERR  = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic        direction;
    logic [2:0]  bits_per_pixel;
    logic [63:0] message_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  pixel_out;
    logic        byte_taken;
    logic        byte_valid;
    logic [7:0]  byte_out;
    logic [63:0] decoded_length;
    logic [1:0]  status;
  } result_t;

endpackage

// ----- hdl/lpsc_intf.sv -----
// ----------------------------------------------------------------------------
// LSB pixel steganography codec channels
// Valid/ready channels for pixel items, results and register writes.
// ----------------------------------------------------------------------------
interface lpsc_pix_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] pixel_in;
  logic [7:0] message_byte;

  modport source (output valid, output command, output pixel_in, output message_byte,
                  input ready);
  modport sink   (input valid, input command, input pixel_in, input message_byte,
                  output ready);
endinterface

interface lpsc_res_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pixel_out;
  logic        byte_taken;
  logic        byte_valid;
  logic [7:0]  byte_out;
  logic [63:0] decoded_length;
  logic [1:0]  status;

  modport source (output valid, output pixel_out, output byte_taken, output byte_valid,
                  output byte_out, output decoded_length, output status, input ready);
  modport sink   (input valid, input pixel_out, input byte_taken, input byte_valid,
                  input byte_out, input decoded_length, input status, output ready);
endinterface

interface lpsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [63:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

// ----- hdl/lpsc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// LSB pixel steganography codec configuration registers
// Holds direction, embed rate and embed message length.
// ----------------------------------------------------------------------------
module lpsc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [lpsc_pkg::CfgIdxW-1:0]   wr_index_i,
  input  logic [lpsc_pkg::CfgDataW-1:0]  wr_data_i,
  output lpsc_pkg::cfg_t                 cfg_o
);
  import lpsc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        CFG_DIRECTION:      cfg_d.direction      = wr_data_i[0];
        CFG_BITS_PER_PIXEL: cfg_d.bits_per_pixel = wr_data_i[2:0];
        CFG_MESSAGE_LENGTH: cfg_d.message_length = wr_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.direction      <= 1'b0;
      cfg_q.bits_per_pixel <= RATE_ONE;
      cfg_q.message_length <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/lpsc_core.sv -----
// ----------------------------------------------------------------------------
// LSB pixel steganography codec frame engine
// Frame state and the per-pixel embed and extract logic.
// ----------------------------------------------------------------------------
module lpsc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              command_i,
  input  logic [7:0]        pixel_in_i,
  input  logic [7:0]        message_byte_i,
  input  lpsc_pkg::cfg_t    cfg_i,
  output lpsc_pkg::result_t result_o
);
  import lpsc_pkg::*;

  phase_e      phase_q, phase_d;
  logic [2:0]  chunk_q, chunk_d;
  logic [2:0]  hdr_idx_q, hdr_idx_d;
  logic [63:0] msg_count_q, msg_count_d;
  logic [7:0]  asm_q, asm_d;
  logic [7:0]  magic_q, magic_d;
  logic [63:0] flen_q, flen_d;
  logic [31:0] frate_q, frate_d;

  logic        extracting;
  logic [7:0]  hdr_byte;
  logic [7:0]  asm_hdr;
  logic [7:0]  magic_next;
  logic [31:0] frate_next;
  logic [63:0] flen_final;
  logic [31:0] frate_final;
  logic        rate_ok;
  logic [7:0]  mask;
  logic [2:0]  shamt;
  logic        last_chunk;
  logic [7:0]  asm_msg;
  logic [63:0] count_inc;
  result_t     res;

  assign extracting = cfg_i.direction;

  always_comb begin
    unique case (phase_q)
      PH_MAGIC:  hdr_byte = (MAGIC_EXPECTED >> {hdr_idx_q[1:0], 2'b00}) & HDR_BYTE_MASK;
      PH_LENGTH: hdr_byte = 8'(cfg_i.message_length >> {hdr_idx_q, 3'b000});
      default:   hdr_byte = (8'(cfg_i.bits_per_pixel) >> {hdr_idx_q[1:0], 2'b00})
                            & HDR_BYTE_MASK;
    endcase
  end

  assign asm_hdr = asm_q | (8'(pixel_in_i[0]) << chunk_q);

  always_comb begin
    unique case (hdr_idx_q[1:0])
      2'd0:    magic_next = magic_q | asm_hdr;
      2'd1:    magic_next = magic_q | {asm_hdr[3:0], 4'h0};
      default: magic_next = magic_q;
    endcase
  end

  assign frate_next  = frate_q | (32'(asm_hdr) << {hdr_idx_q[1:0], 2'b00});
  assign flen_final  = extracting ? flen_q : cfg_i.message_length;
  assign frate_final = extracting ? frate_next : 32'(cfg_i.bits_per_pixel);
  assign rate_ok     = (frate_final == 32'(RATE_ONE)) || (frate_final == 32'(RATE_TWO))
                    || (frate_final == 32'(RATE_FOUR));

  always_comb begin
    case (frate_q[2:0])
      RATE_TWO: begin
        mask       = 8'h03;
        shamt      = {chunk_q[1:0], 1'b0};
        last_chunk = (chunk_q >= 3'd3);
      end
      RATE_FOUR: begin
        mask       = 8'h0F;
        shamt      = {chunk_q[0], 2'b00};
        last_chunk = (chunk_q >= 3'd1);
      end
      default: begin
        mask       = 8'h01;
        shamt      = chunk_q;
        last_chunk = (chunk_q == 3'd7);
      end
    endcase
  end

  assign asm_msg   = asm_q | ((pixel_in_i & mask) << shamt);
  assign count_inc = msg_count_q + 64'd1;

  always_comb begin
    phase_d     = phase_q;
    chunk_d     = chunk_q;
    hdr_idx_d   = hdr_idx_q;
    msg_count_d = msg_count_q;
    asm_d       = asm_q;
    magic_d     = magic_q;
    flen_d      = flen_q;
    frate_d     = frate_q;
    res         = '0;
    res.pixel_out = pixel_in_i;

    if (command_i) begin
      phase_d     = PH_MAGIC;
      chunk_d     = '0;
      hdr_idx_d   = '0;
      msg_count_d = '0;
      asm_d       = '0;
      magic_d     = '0;
      flen_d      = '0;
      frate_d     = '0;
    end else begin
      unique case (phase_q)
        PH_MAGIC, PH_LENGTH, PH_RATE: begin
          if (extracting) begin
            asm_d = asm_hdr;
          end else begin
            res.pixel_out = {pixel_in_i[7:1], hdr_byte[chunk_q]};
          end
          chunk_d = chunk_q + 3'd1;
          if (chunk_q == 3'd7) begin
            asm_d = '0;
            unique case (phase_q)
              PH_MAGIC: begin
                if (extracting) begin
                  magic_d = magic_next;
                end
                if (extracting && hdr_idx_q == 3'd3 && magic_next != MAGIC_EXPECTED) begin
                  phase_d = PH_MAGIC_ERR;
                end else if (hdr_idx_q == 3'd3) begin
                  phase_d   = PH_LENGTH;
                  hdr_idx_d = '0;
                end else begin
                  hdr_idx_d = hdr_idx_q + 3'd1;
                end
              end
              PH_LENGTH: begin
                if (extracting) begin
                  flen_d = flen_q | (64'(asm_hdr) << {hdr_idx_q, 3'b000});
                end
                hdr_idx_d = hdr_idx_q + 3'd1;
                if (hdr_idx_q == 3'd7) begin
                  phase_d = PH_RATE;
                end
              end
              default: begin
                if (extracting) begin
                  frate_d = frate_next;
                end
                if (hdr_idx_q == 3'd3) begin
                  hdr_idx_d = '0;
                  flen_d    = flen_final;
                  frate_d   = frate_final;
                  if (!rate_ok) begin
                    phase_d = PH_RATE_ERR;
                  end else if (flen_final == '0) begin
                    phase_d = PH_DONE;
                  end else begin
                    phase_d = PH_MESSAGE;
                  end
                end else begin
                  hdr_idx_d = hdr_idx_q + 3'd1;
                end
              end
            endcase
          end
        end
        PH_MESSAGE: begin
          if (extracting) begin
            asm_d = asm_msg;
          end else begin
            res.pixel_out = (pixel_in_i & ~mask) | ((message_byte_i >> shamt) & mask);
          end
          if (last_chunk) begin
            chunk_d     = '0;
            msg_count_d = count_inc;
            asm_d       = '0;
            if (extracting) begin
              res.byte_valid = 1'b1;
              res.byte_out   = asm_msg;
            end else begin
              res.byte_taken = 1'b1;
            end
            if (count_inc >= flen_q) begin
              phase_d = PH_DONE;
            end
          end else begin
            chunk_d = chunk_q + 3'd1;
          end
        end
        default: ;
      endcase
    end

    unique case (phase_d)
      PH_DONE:      res.status = ST_DONE;
      PH_MAGIC_ERR: res.status = ST_MAGIC_ERR;
      PH_RATE_ERR:  res.status = ST_RATE_ERR;
      default:      res.status = ST_RUNNING;
    endcase
    res.decoded_length = extracting ? flen_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_MAGIC;
      chunk_q     <= '0;
      hdr_idx_q   <= '0;
      msg_count_q <= '0;
      asm_q       <= '0;
      magic_q     <= '0;
      flen_q      <= '0;
      frate_q     <= '0;
    end else if (accept_i) begin
      phase_q     <= phase_d;
      chunk_q     <= chunk_d;
      hdr_idx_q   <= hdr_idx_d;
      msg_count_q <= msg_count_d;
      asm_q       <= asm_d;
      magic_q     <= magic_d;
      flen_q      <= flen_d;
      frate_q     <= frate_d;
    end
  end

  assign result_o = res;

endmodule

// ----- hdl/lpsc_out_buf.sv -----
// ----------------------------------------------------------------------------
// LSB pixel steganography codec result register
// Holds one result beat and lets a new beat in whenever it drains.
// ----------------------------------------------------------------------------
module lpsc_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  lpsc_pkg::result_t result_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output lpsc_pkg::result_t out_data_o,
  output logic              in_ready_o
);
  import lpsc_pkg::*;

  logic    valid_q, valid_d;
  result_t data_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign valid_d    = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// ----- hdl/lsb_pixel_stego_codec_top.sv -----
// ----------------------------------------------------------------------------
// LSB pixel steganography codec
// A result beat is registered and appears in the cycle after its pixel beat is accepted.
// One pixel beat per cycle while out_ch_o.ready is high; the result register
// drains as the next pixel is taken; each result is computed combinationally.
// Reset clears the frame to the start of the header and loads the registers
// with direction embed, one bit per pixel and a message length of zero.
// ----------------------------------------------------------------------------
module lsb_pixel_stego_codec_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpsc_pix_if.sink   in_ch_i,
  lpsc_res_if.source out_ch_o,
  lpsc_cfg_if.sink   cfg_i
);
  import lpsc_pkg::*;

  cfg_t    cfg;
  result_t result;
  result_t out_data;
  logic    in_ready;
  logic    accept;

  assign in_ch_i.ready = in_ready;
  assign accept        = in_ch_i.valid && in_ready;
  assign cfg_i.ready   = 1'b1;

  lpsc_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.reg_index),
    .wr_data_i  (cfg_i.wdata),
    .cfg_o      (cfg)
  );

  lpsc_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .command_i      (in_ch_i.command),
    .pixel_in_i     (in_ch_i.pixel_in),
    .message_byte_i (in_ch_i.message_byte),
    .cfg_i          (cfg),
    .result_o       (result)
  );

  lpsc_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .result_i    (result),
    .out_ready_i (out_ch_o.ready),
    .out_valid_o (out_ch_o.valid),
    .out_data_o  (out_data),
    .in_ready_o  (in_ready)
  );

  assign out_ch_o.pixel_out      = out_data.pixel_out;
  assign out_ch_o.byte_taken     = out_data.byte_taken;
  assign out_ch_o.byte_valid     = out_data.byte_valid;
  assign out_ch_o.byte_out       = out_data.byte_out;
  assign out_ch_o.decoded_length = out_data.decoded_length;
  assign out_ch_o.status         = out_data.status;

`ifndef NO_ASSERTIONS
  a_taken_valid_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch_o.valid |-> !(out_ch_o.byte_taken && out_ch_o.byte_valid))
    else $error("byte_taken and byte_valid high on the same beat");

  a_restart_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_ch_i.command) |=> (out_ch_o.valid && out_ch_o.status == ST_RUNNING
      && !out_ch_o.byte_taken && !out_ch_o.byte_valid))
    else $error("restart beat did not give a clean running result");

  a_taken_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch_o.valid && out_ch_o.byte_taken) |->
      (out_ch_o.status == ST_RUNNING || out_ch_o.status == ST_DONE))
    else $error("byte taken outside the message section");
`endif

endmodule
